/* rtl/core/plcd_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// plcd_pkg
// Shared types, codes and helpers of the parallel LCD bus write sequencer.
// ----------------------------------------------------------------------------
package plcd_pkg;

	localparam int BUS_W   = 24;
	localparam int VALUE_W = 32;
	localparam int OP_W    = 2;
	localparam int IDX_W   = 2;
	localparam int CDATA_W = 2;
	localparam int Q_AW    = 2;
	localparam int Q_DEPTH = 1 << Q_AW;

	localparam logic [OP_W-1:0] OP_CMD   = 2'd0;
	localparam logic [OP_W-1:0] OP_DATA  = 2'd1;
	localparam logic [OP_W-1:0] OP_PIXEL = 2'd2;

	localparam logic [1:0] PIX_16     = 2'd0;
	localparam logic [1:0] PIX_RGB565 = 2'd1;
	localparam logic [1:0] PIX_BYTES3 = 2'd2;

	localparam logic [1:0] BW_8  = 2'd0;
	localparam logic [1:0] BW_16 = 2'd1;
	localparam logic [1:0] BW_18 = 2'd2;

	localparam logic [IDX_W-1:0] REG_BUS_WIDTH  = 2'd0;
	localparam logic [IDX_W-1:0] REG_PIXEL_MODE = 2'd1;
	localparam logic [IDX_W-1:0] REG_WR_HIGH    = 2'd2;
	localparam logic [IDX_W-1:0] REG_RS_CMD_HI  = 2'd3;

	localparam logic [VALUE_W-1:0] R_MASK = 32'h1f << 19;
	localparam logic [VALUE_W-1:0] G_MASK = 32'h3f << 10;
	localparam logic [VALUE_W-1:0] B_MASK = 32'h1f << 3;

	typedef struct packed {
		logic [1:0] bus_width_mode;
		logic [1:0] pixel_mode;
		logic       write_strobe_active_high;
		logic       select_command_high;
	} cfg_t;

	typedef struct packed {
		logic [BUS_W-1:0] word;
		logic             is_data;
		logic             last_w;
	} word_t;

	function automatic logic [BUS_W-1:0] bus_mask(input logic [1:0] mode);
		logic [BUS_W-1:0] m;
		case (mode)
			BW_8:    m = 24'h0000ff;
			BW_16:   m = 24'h00ffff;
			BW_18:   m = 24'h03ffff;
			default: m = 24'hffffff;
		endcase
		return m;
	endfunction

endpackage
`default_nettype wire

/* rtl/core/plcd_item_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// plcd_item_if
// Request channel carrying one operation and its value.
// ----------------------------------------------------------------------------
interface plcd_item_if;
	logic        valid;
	logic        ready;
	logic [1:0]  operation;
	logic [31:0] value;

	modport source (output valid, output operation, output value, input ready);
	modport sink (input valid, input operation, input value, output ready);
endinterface
`default_nettype wire

/* rtl/core/plcd_result_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// plcd_result_if
// Result channel carrying the pin levels and bus value of one phase.
// ----------------------------------------------------------------------------
interface plcd_result_if;
	logic        valid;
	logic        ready;
	logic        select_pin;
	logic        strobe_pin;
	logic [23:0] bus_word;
	logic        last;

	modport source (output valid, output select_pin, output strobe_pin,
		output bus_word, output last, input ready);
	modport sink (input valid, input select_pin, input strobe_pin,
		input bus_word, input last, output ready);
endinterface
`default_nettype wire

/* rtl/core/plcd_cfg_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// plcd_cfg_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface plcd_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] index;
	logic [1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

/* rtl/core/plcd_cfg_regs.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// plcd_cfg_regs
// Configuration register file, written through the register channel.
// ----------------------------------------------------------------------------
module plcd_cfg_regs
	import plcd_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	plcd_cfg_if.sink   cfg,
	output cfg_t       cfg_out
);

	cfg_t cfg_q;

	assign cfg.ready = 1'b1;
	assign cfg_out   = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_BUS_WIDTH:  cfg_q.bus_width_mode <= cfg.data;
				REG_PIXEL_MODE: cfg_q.pixel_mode <= cfg.data;
				REG_WR_HIGH:    cfg_q.write_strobe_active_high <= cfg.data[0];
				REG_RS_CMD_HI:  cfg_q.select_command_high <= cfg.data[0];
				default: begin
				end
			endcase
		end
	end

endmodule
`default_nettype wire

/* rtl/core/plcd_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// plcd_front
// Accepts requests, splits them into masked bus words and queues them.
// ----------------------------------------------------------------------------
module plcd_front
	import plcd_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire cfg_t  cfg_in,
	plcd_item_if.sink  item,
	input  wire logic  q_full,
	output logic       q_push,
	output word_t      q_data
);

	logic [BUS_W-1:0] words_q [3];
	logic [1:0]       idx_q;
	logic [1:0]       left_q;
	logic             is_data_q;
	logic [BUS_W-1:0] w_n [3];
	logic [1:0]       n_n;
	logic [BUS_W-1:0] mask;
	logic [VALUE_W-1:0] v;
	logic [VALUE_W-1:0] r;
	logic [VALUE_W-1:0] g;
	logic [VALUE_W-1:0] b;
	logic [VALUE_W-1:0] t0;
	logic [VALUE_W-1:0] t1;
	logic             accept;

	assign item.ready = (left_q == 2'd0);
	assign accept     = item.valid && item.ready;
	assign q_push     = (left_q != 2'd0) && !q_full;

	assign q_data.word    = words_q[idx_q];
	assign q_data.is_data = is_data_q;
	assign q_data.last_w  = (left_q == 2'd1);

	always_comb begin
		mask = bus_mask(cfg_in.bus_width_mode);
		v    = item.value;
		r    = v & R_MASK;
		g    = v & G_MASK;
		b    = v & B_MASK;
		t0   = '0;
		t1   = '0;
		w_n[0] = '0;
		w_n[1] = '0;
		w_n[2] = '0;
		n_n    = 2'd0;
		case (item.operation)
			OP_CMD, OP_DATA: begin
				w_n[0] = v[BUS_W-1:0] & mask;
				n_n    = 2'd1;
			end
			OP_PIXEL: begin
				case (cfg_in.pixel_mode)
					PIX_16: begin
						t0     = {16'd0, v[15:0]} >> 8;
						w_n[0] = t0[BUS_W-1:0] & mask;
						w_n[1] = {8'd0, v[15:0]} & mask;
						n_n    = 2'd2;
					end
					PIX_RGB565: begin
						t0     = (r >> 16) | (g >> 13);
						t1     = (g >> 5) | (b >> 3);
						w_n[0] = t0[BUS_W-1:0] & mask;
						w_n[1] = t1[BUS_W-1:0] & mask;
						n_n    = 2'd2;
					end
					PIX_BYTES3: begin
						t0     = v >> 16;
						t1     = v >> 8;
						w_n[0] = t0[BUS_W-1:0] & mask;
						w_n[1] = t1[BUS_W-1:0] & mask;
						w_n[2] = v[BUS_W-1:0] & mask;
						n_n    = 2'd3;
					end
					default: n_n = 2'd0;
				endcase
			end
			default: n_n = 2'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= 2'd0;
			idx_q  <= 2'd0;
		end else if (accept) begin
			left_q <= n_n;
			idx_q  <= 2'd0;
		end else if (q_push) begin
			left_q <= left_q - 2'd1;
			idx_q  <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			words_q[0] <= w_n[0];
			words_q[1] <= w_n[1];
			words_q[2] <= w_n[2];
			is_data_q  <= (item.operation != OP_CMD);
		end
	end

endmodule
`default_nettype wire

/* rtl/core/plcd_fifo.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// plcd_fifo
// Short word queue between the front and the pin sequencer.
// ----------------------------------------------------------------------------
module plcd_fifo
	import plcd_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire word_t push_data,
	input  wire logic  pop,
	output logic       full,
	output logic       empty,
	output word_t      head
);

	word_t           mem_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_ptr_q;
	logic [Q_AW-1:0] rd_ptr_q;
	logic [Q_AW:0]   count_q;

	assign full  = (count_q == Q_DEPTH[Q_AW:0]);
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

endmodule
`default_nettype wire

/* rtl/core/plcd_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// plcd_back
// Pin sequencer: runs the five write phases of each queued bus word.
// ----------------------------------------------------------------------------
module plcd_back
	import plcd_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire cfg_t   cfg_in,
	input  wire logic   q_empty,
	input  wire word_t  q_head,
	output logic        q_pop,
	plcd_result_if.source result
);

	localparam logic [2:0] PH_SELECT  = 3'd0;
	localparam logic [2:0] PH_DRIVE   = 3'd1;
	localparam logic [2:0] PH_ASSERT  = 3'd2;
	localparam logic [2:0] PH_RELEASE = 3'd3;
	localparam logic [2:0] PH_RETURN  = 3'd4;

	logic             active_q;
	logic [2:0]       phase_q;
	word_t            cur_q;
	logic [BUS_W-1:0] held_q;
	logic             ov_q;
	logic             sel_q;
	logic             wr_q;
	logic [BUS_W-1:0] bus_q;
	logic             last_q;
	logic             adv;
	logic             asserted;
	logic             released;
	logic             lvl_sel;
	logic             opp_sel;

	assign adv      = !ov_q || result.ready;
	assign q_pop    = adv && !active_q && !q_empty;
	assign asserted = cfg_in.write_strobe_active_high;
	assign released = !asserted;
	assign lvl_sel  = cur_q.is_data ^ cfg_in.select_command_high;
	assign opp_sel  = !lvl_sel;

	assign result.valid      = ov_q;
	assign result.select_pin = sel_q;
	assign result.strobe_pin = wr_q;
	assign result.bus_word   = bus_q;
	assign result.last       = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			phase_q  <= PH_SELECT;
			ov_q     <= 1'b0;
			held_q   <= '0;
		end else if (adv) begin
			if (active_q) begin
				ov_q <= 1'b1;
				if (phase_q == PH_RETURN) begin
					active_q <= 1'b0;
					phase_q  <= PH_SELECT;
				end else begin
					phase_q <= phase_q + 3'd1;
				end
			end else if (!q_empty) begin
				ov_q     <= 1'b1;
				active_q <= 1'b1;
				phase_q  <= PH_DRIVE;
				held_q   <= q_head.word;
			end else begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q  <= q_head;
			sel_q  <= q_head.is_data ^ cfg_in.select_command_high;
			wr_q   <= released;
			bus_q  <= held_q;
			last_q <= 1'b0;
		end else if (adv && active_q) begin
			bus_q  <= cur_q.word;
			sel_q  <= (phase_q == PH_RETURN) ? opp_sel : lvl_sel;
			wr_q   <= (phase_q == PH_ASSERT) ? asserted : released;
			last_q <= (phase_q == PH_RETURN) ? cur_q.last_w : 1'b0;
		end
	end

endmodule
`default_nettype wire

/* rtl/core/parallel_lcd_bus_write_sequencer.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// parallel_lcd_bus_write_sequencer
// 8080-style LCD write sequencer: requests in, one result per pin phase out.
// ----------------------------------------------------------------------------
// Each request (command word, data word or pixel) becomes one, two or three
// bus words, and each bus word takes five pin phases, one result per cycle
// while words are queued and the result side is ready. The pin sequencer sets
// that rate; the front splits requests into a four-word queue, so it takes the
// next request while earlier words are still being sent. Operation 3 and pixels
// in pixel mode 3 are accepted and dropped. Registers must be written only while
// the block is idle; the block itself does not enforce this.
module parallel_lcd_bus_write_sequencer
	import plcd_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	plcd_cfg_if.sink      cfg,
	plcd_item_if.sink     item,
	plcd_result_if.source result
);

	cfg_t  cfg_w;
	logic  q_full;
	logic  q_empty;
	logic  q_push;
	logic  q_pop;
	word_t q_in;
	word_t q_head;

	plcd_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.cfg_out (cfg_w)
	);

	plcd_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg_in (cfg_w),
		.item   (item),
		.q_full (q_full),
		.q_push (q_push),
		.q_data (q_in)
	);

	plcd_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.pop       (q_pop),
		.full      (q_full),
		.empty     (q_empty),
		.head      (q_head)
	);

	plcd_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_in  (cfg_w),
		.q_empty (q_empty),
		.q_head  (q_head),
		.q_pop   (q_pop),
		.result  (result)
	);

endmodule
`default_nettype wire

/* sim/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the parallel LCD bus write sequencer. Directed
// requests hit the register extremes, every operation and pixel mode and the
// dropped codes. Random requests then run under random stalls on both sides,
// a long output hold-off and a drained pause. Every pin phase is compared
// with a cycle-free prediction of the write sequence.
// ----------------------------------------------------------------------------
module testbench;
	import plcd_pkg::*;

	localparam logic [OP_W-1:0] OP_UNUSED  = 2'd3;
	localparam logic [1:0]      PIX_UNUSED = 2'd3;
	localparam logic [1:0]      BW_24      = 2'd3;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SETTLE_CYCLES  = 20;
	localparam int LONG_HOLD      = 300;
	localparam int MAX_REPORTS    = 10;

	typedef struct packed {
		logic             select_pin;
		logic             strobe_pin;
		logic [BUS_W-1:0] bus_word;
		logic             last;
	} phase_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	plcd_cfg_if    cfg_bus ();
	plcd_item_if   req_bus ();
	plcd_result_if phase_bus ();

	parallel_lcd_bus_write_sequencer dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_bus),
		.item   (req_bus),
		.result (phase_bus)
	);

	always #4 clk = ~clk;

	// predicted pin phases and the mirrored block state
	phase_t           expected_phases[$];
	cfg_t             cfg_mirror = '0;
	logic [BUS_W-1:0] bus_held = '0;

	int mismatches = 0;
	int phases_checked = 0;
	int cmd_count = 0;
	int data_count = 0;
	int pixel_count = 0;
	int dropped_count = 0;
	int reg_writes = 0;

	bit sender_idling = 1'b1;
	bit sink_idling = 1'b1;
	int hold_request = 0;

	function automatic logic [BUS_W-1:0] width_mask(input logic [1:0] mode);
		case (mode)
			BW_8:    return 24'h0000ff;
			BW_16:   return 24'h00ffff;
			BW_18:   return 24'h03ffff;
			default: return 24'hffffff;
		endcase
	endfunction

	function automatic logic select_level(input logic at_data);
		return at_data ? ~cfg_mirror.select_command_high : cfg_mirror.select_command_high;
	endfunction

	// five pin phases of one bus word
	function automatic void queue_word(input logic [BUS_W-1:0] word, input logic is_data,
			input logic closes);
		logic             asserted;
		logic             released;
		logic             sel;
		logic [BUS_W-1:0] w;
		asserted = cfg_mirror.write_strobe_active_high;
		released = ~asserted;
		sel = select_level(is_data);
		w = word & width_mask(cfg_mirror.bus_width_mode);
		expected_phases.push_back(phase_t'{sel, released, bus_held, 1'b0});
		bus_held = w;
		expected_phases.push_back(phase_t'{sel, released, w, 1'b0});
		expected_phases.push_back(phase_t'{sel, asserted, w, 1'b0});
		expected_phases.push_back(phase_t'{sel, released, w, 1'b0});
		expected_phases.push_back(phase_t'{select_level(~is_data), released, w, closes});
	endfunction

	function automatic void predict_request(input logic [OP_W-1:0] op,
			input logic [VALUE_W-1:0] value);
		logic [VALUE_W-1:0] r;
		logic [VALUE_W-1:0] g;
		logic [VALUE_W-1:0] b;
		logic [VALUE_W-1:0] hi;
		logic [VALUE_W-1:0] lo;
		case (op)
			OP_CMD: begin
				cmd_count++;
				queue_word(value[BUS_W-1:0], 1'b0, 1'b1);
			end
			OP_DATA: begin
				data_count++;
				queue_word(value[BUS_W-1:0], 1'b1, 1'b1);
			end
			OP_PIXEL: begin
				case (cfg_mirror.pixel_mode)
					PIX_16: begin
						pixel_count++;
						queue_word(BUS_W'(value[15:8]), 1'b1, 1'b0);
						queue_word(BUS_W'(value[15:0]), 1'b1, 1'b1);
					end
					PIX_RGB565: begin
						pixel_count++;
						r = value & R_MASK;
						g = value & G_MASK;
						b = value & B_MASK;
						hi = (r >> 16) | (g >> 13);
						lo = (g >> 5) | (b >> 3);
						queue_word(hi[BUS_W-1:0], 1'b1, 1'b0);
						queue_word(lo[BUS_W-1:0], 1'b1, 1'b1);
					end
					PIX_BYTES3: begin
						pixel_count++;
						hi = value >> 16;
						lo = value >> 8;
						queue_word(hi[BUS_W-1:0], 1'b1, 1'b0);
						queue_word(lo[BUS_W-1:0], 1'b1, 1'b0);
						queue_word(value[BUS_W-1:0], 1'b1, 1'b1);
					end
					default: dropped_count++;
				endcase
			end
			default: dropped_count++;
		endcase
	endfunction

	// result checker, register mirror and request prediction
	always @(posedge clk) begin
		phase_t seen;
		phase_t want;
		if (phase_bus.valid && phase_bus.ready) begin
			seen = phase_t'{phase_bus.select_pin, phase_bus.strobe_pin, phase_bus.bus_word,
				phase_bus.last};
			phases_checked++;
			if (expected_phases.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: unexpected phase sel %b wr %b bus %06h last %b", $realtime,
						seen.select_pin, seen.strobe_pin, seen.bus_word, seen.last);
			end else begin
				want = expected_phases.pop_front();
				if (seen !== want) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display(
							"%0t: mismatch exp/act sel %b/%b wr %b/%b bus %06h/%06h last %b/%b",
							$realtime,
							want.select_pin, seen.select_pin, want.strobe_pin, seen.strobe_pin,
							want.bus_word, seen.bus_word, want.last, seen.last);
				end
			end
		end
		if (cfg_bus.valid && cfg_bus.ready) begin
			reg_writes++;
			case (cfg_bus.index)
				REG_BUS_WIDTH:  cfg_mirror.bus_width_mode = cfg_bus.data;
				REG_PIXEL_MODE: cfg_mirror.pixel_mode = cfg_bus.data;
				REG_WR_HIGH:    cfg_mirror.write_strobe_active_high = cfg_bus.data[0];
				REG_RS_CMD_HI:  cfg_mirror.select_command_high = cfg_bus.data[0];
				default: begin
				end
			endcase
		end
		if (req_bus.valid && req_bus.ready)
			predict_request(req_bus.operation, req_bus.value);
	end

	// result side: random stall bursts and the long hold-off
	always @(posedge clk) begin
		int stall_left;
		int hold_left;
		if (hold_request > 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			phase_bus.ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			phase_bus.ready <= 1'b0;
		end else if (sink_idling && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(0, 14);
			phase_bus.ready <= 1'b0;
		end else begin
			phase_bus.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		int quiet_cycles;
		if ((req_bus.valid && req_bus.ready) || (phase_bus.valid && phase_bus.ready) ||
				(cfg_bus.valid && cfg_bus.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no handshake for %0d cycles, %0d phases outstanding",
				quiet_cycles, expected_phases.size());
			$display("FAILED: results differ");
			$finish;
		end
	end

	task automatic send_request(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] value);
		if (sender_idling && $urandom_range(0, 3) == 0) begin
			req_bus.valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		req_bus.valid <= 1'b1;
		req_bus.operation <= op;
		req_bus.value <= value;
		do @(posedge clk); while (!req_bus.ready);
	endtask

	task automatic wait_drained();
		req_bus.valid <= 1'b0;
		// let the checker see the last accepted request first
		@(posedge clk);
		while (expected_phases.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CDATA_W-1:0] data);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data <= data;
		do @(posedge clk); while (!cfg_bus.ready);
	endtask

	task automatic set_config(input logic [1:0] bw, input logic [1:0] pm, input logic wr_high,
			input logic rs_cmd_high);
		wait_drained();
		write_reg(REG_BUS_WIDTH, bw);
		write_reg(REG_PIXEL_MODE, pm);
		write_reg(REG_WR_HIGH, CDATA_W'(wr_high));
		write_reg(REG_RS_CMD_HI, CDATA_W'(rs_cmd_high));
		cfg_bus.valid <= 1'b0;
	endtask

	task automatic random_config();
		logic [1:0] pm;
		pm = ($urandom_range(0, 7) == 0) ? PIX_UNUSED : 2'($urandom_range(0, 2));
		set_config(2'($urandom_range(0, 3)), pm, 1'($urandom_range(0, 1)),
			1'($urandom_range(0, 1)));
	endtask

	// returns 1 when the request produces pin phases
	task automatic send_random_request(output bit produces);
		logic [OP_W-1:0]    op;
		logic [VALUE_W-1:0] value;
		op = ($urandom_range(0, 15) == 0) ? OP_UNUSED : OP_W'($urandom_range(0, 2));
		case ($urandom_range(0, 7))
			0:       value = '0;
			1:       value = '1;
			default: value = $urandom;
		endcase
		send_request(op, value);
		produces = (op != OP_UNUSED) && !(op == OP_PIXEL && cfg_mirror.pixel_mode == PIX_UNUSED);
	endtask

	task automatic send_random_requests(input int count);
		int  sent;
		bit  produces;
		sent = 0;
		while (sent < count) begin
			send_random_request(produces);
			if (produces)
				sent++;
		end
	endtask

	task automatic test_reset_defaults();
		send_request(OP_CMD, 32'h0000_0000);
		send_request(OP_DATA, 32'hffff_ffff);
		send_request(OP_PIXEL, 32'h1234_abcd);
	endtask

	task automatic test_bus_widths();
		for (int bw = 0; bw < 4; bw++) begin
			set_config(2'(bw), PIX_16, 1'b0, 1'b0);
			send_request(OP_CMD, 32'hffff_ffff);
			send_request(OP_DATA, 32'ha5a5_a5a5);
		end
	endtask

	task automatic test_pixel_modes();
		set_config(BW_24, PIX_16, 1'b0, 1'b0);
		send_request(OP_PIXEL, 32'hffff_ffff);
		set_config(BW_24, PIX_RGB565, 1'b0, 1'b0);
		send_request(OP_PIXEL, 32'hffff_ffff);
		set_config(BW_24, PIX_BYTES3, 1'b0, 1'b0);
		send_request(OP_PIXEL, 32'hffff_ffff);
		set_config(BW_18, PIX_BYTES3, 1'b0, 1'b0);
		send_request(OP_PIXEL, 32'h00fe_dcba);
	endtask

	task automatic test_polarities();
		set_config(BW_16, PIX_RGB565, 1'b1, 1'b1);
		send_request(OP_CMD, 32'h0000_002c);
		send_request(OP_DATA, 32'h0000_ffff);
		// pins re-derived under new polarity between requests
		set_config(BW_16, PIX_RGB565, 1'b0, 1'b1);
		send_request(OP_PIXEL, 32'h00f8_fcf8);
	endtask

	task automatic test_unused_codes();
		send_request(OP_UNUSED, 32'hffff_ffff);
		set_config(BW_24, PIX_UNUSED, 1'b1, 1'b0);
		send_request(OP_PIXEL, 32'hffff_ffff);
		send_request(OP_DATA, 32'h0012_3456);
	endtask

	task automatic test_random_settings();
		for (int round = 0; round < 8; round++) begin
			if (round == 0)
				set_config(BW_8, PIX_16, 1'b0, 1'b0);
			else if (round == 1)
				set_config(BW_24, PIX_BYTES3, 1'b1, 1'b1);
			else
				random_config();
			sender_idling = $urandom_range(0, 3) != 0;
			sink_idling = $urandom_range(0, 3) != 0;
			send_random_requests(40);
		end
		sender_idling = 1'b1;
		sink_idling = 1'b1;
	endtask

	task automatic test_output_backpressure();
		set_config(BW_24, PIX_BYTES3, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
		sender_idling = 1'b0;
		hold_request = LONG_HOLD;
		send_random_requests(20);
		wait_drained();
		sender_idling = 1'b1;
	endtask

	task automatic test_sender_pause();
		for (int round = 0; round < 3; round++) begin
			random_config();
			send_random_requests(10);
			wait_drained();
		end
	endtask

	task automatic test_back_to_back();
		sender_idling = 1'b0;
		sink_idling = 1'b0;
		random_config();
		send_random_requests(40);
		wait_drained();
	endtask

	initial begin
		cfg_bus.valid = 1'b0;
		cfg_bus.index = '0;
		cfg_bus.data = '0;
		req_bus.valid = 1'b0;
		req_bus.operation = OP_CMD;
		req_bus.value = '0;
		phase_bus.ready = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		test_reset_defaults();
		test_bus_widths();
		test_pixel_modes();
		test_polarities();
		test_unused_codes();
		test_random_settings();
		test_output_backpressure();
		test_sender_pause();
		test_back_to_back();

		if (expected_phases.size() != 0) begin
			mismatches++;
			$display("%0d expected phases never arrived", expected_phases.size());
		end
		$display("covered %0d command, %0d data and %0d pixel requests, %0d dropped, %0d reg writes",
			cmd_count, data_count, pixel_count, dropped_count, reg_writes);
		$display("checked %0d pin phases, %0d mismatches", phases_checked, mismatches);
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
